[sv/slee_pkg.sv]
// ----------------------------------------------------------------------------
// slee_pkg
// Types, constants and byte-encoding functions shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slee_pkg;

   localparam logic [6:0] CHAR_BACKSLASH = 7'd92;
   localparam logic [6:0] CHAR_ZERO      = 7'd48;
   localparam logic [6:0] CHAR_X         = 7'd120;
   localparam logic [6:0] CHAR_HEX_ALPHA = 7'd87;  // 'a' - 10
   localparam logic [7:0] PRINT_LOW      = 8'd32;
   localparam logic [7:0] PRINT_HIGH     = 8'd126;

   // Register indexes on the CSR port (byte address 4*index)
   localparam logic REG_HEX_MODE = 1'b0;
   localparam logic REG_GUARD    = 1'b1;

   typedef enum logic [1:0] {
      CLASS_PRINTABLE = 2'd0,
      CLASS_SHORT     = 2'd1,
      CLASS_NUMERIC   = 2'd2
   } class_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_run_last;
      logic       out_end;
   } rsp_type;

   typedef struct packed {
      logic hex_mode;
      logic octal_digit_guard;
   } cfg_type;

   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [2:0]      len;
      class_type       cls;
   } enc_type;

   // One request's worth of characters: the held byte (a) and the last byte (b)
   typedef struct packed {
      logic [3:0][6:0] a_chars;
      logic [2:0]      a_len;
      logic [3:0][6:0] b_chars;
      logic [2:0]      b_len;
      logic            last;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'd97) && (c <= 8'd102)) ||
             ((c >= 8'd65) && (c <= 8'd70));
   endfunction

   // Letter after the backslash of a short escape, zero when none
   function automatic logic [6:0] short_escape(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         8'd7:    r = 7'd97;
         8'd8:    r = 7'd98;
         8'd9:    r = 7'd116;
         8'd10:   r = 7'd110;
         8'd11:   r = 7'd118;
         8'd12:   r = 7'd102;
         8'd13:   r = 7'd114;
         8'd34:   r = 7'd34;
         8'd39:   r = 7'd39;
         8'd63:   r = 7'd63;
         8'd92:   r = 7'd92;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] hex_digit(input logic [3:0] d);
      return (d < 4'd10) ? (CHAR_ZERO + 7'(d)) : (CHAR_HEX_ALPHA + 7'(d));
   endfunction

   function automatic enc_type numeric_escape(input logic [7:0] c, input logic hex);
      enc_type e;
      e.chars[0] = CHAR_BACKSLASH;
      if (hex) begin
         e.chars[1] = CHAR_X;
         e.chars[2] = hex_digit(c[7:4]);
         e.chars[3] = hex_digit(c[3:0]);
      end else begin
         e.chars[1] = CHAR_ZERO + 7'(c[7:6]);
         e.chars[2] = CHAR_ZERO + 7'(c[5:3]);
         e.chars[3] = CHAR_ZERO + 7'(c[2:0]);
      end
      e.len = 3'd4;
      e.cls = CLASS_NUMERIC;
      return e;
   endfunction

   // Encode byte c given its successor, the config and the previous class
   function automatic enc_type encode(input logic [7:0] c, input logic [7:0] nxt,
                                      input cfg_type cfg, input class_type prior);
      enc_type    e;
      logic [6:0] esc;
      logic       guarded;
      esc     = short_escape(c);
      guarded = cfg.hex_mode ? is_hex_char(c) : (cfg.octal_digit_guard && is_digit(c));
      e       = numeric_escape(c, cfg.hex_mode);
      if (c == 8'd0) begin
         if (!is_digit(nxt)) begin
            e.chars[0] = CHAR_BACKSLASH;
            e.chars[1] = CHAR_ZERO;
            e.len      = 3'd2;
            e.cls      = cfg.hex_mode ? CLASS_SHORT : CLASS_NUMERIC;
         end
      end else if (esc != 7'd0) begin
         e.chars[0] = CHAR_BACKSLASH;
         e.chars[1] = esc;
         e.len      = 3'd2;
         e.cls      = CLASS_SHORT;
      end else if ((prior == CLASS_NUMERIC) && guarded) begin
         e.len = 3'd4;
      end else if ((c >= PRINT_LOW) && (c <= PRINT_HIGH)) begin
         e.chars[0] = c[6:0];
         e.len      = 3'd1;
         e.cls      = CLASS_PRINTABLE;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

[sv/string_literal_escape_encoder_core.sv]
// ----------------------------------------------------------------------------
// string_literal_escape_encoder_core
// Streams raw bytes into the characters of a C string literal body.
// ----------------------------------------------------------------------------
// Each request byte is held until the next one arrives (or is itself marked
// last), then encoded into one to four characters; a last byte flushes the
// held byte and itself, so one request yields up to eight characters. The
// front takes one request per cycle while the request queue has room; the
// back emits exactly one character per cycle into the single result
// register while that register is empty or being popped; a request yields
// one character per printable byte, two per short escape and four per
// numeric escape.
// Configuration: hex_mode at 0x0, octal_digit_guard at 0x4; write only idle.
// ----------------------------------------------------------------------------
`default_nettype none

module string_literal_escape_encoder_core import slee_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic      hex_mode_ff, hex_mode_in;
   logic      guard_ff, guard_in;
   logic      csr_write;
   cfg_type   cfg;
   qstat_type q_stat;
   logic      q_push, q_pop;
   work_type  q_data, q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg.hex_mode          = hex_mode_ff;
   assign cfg.octal_digit_guard = guard_ff;

   always_comb begin
      hex_mode_in = hex_mode_ff;
      guard_in    = guard_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_HEX_MODE: hex_mode_in = csr_pwdata[0];
            REG_GUARD:    guard_in    = csr_pwdata[0];
            default:      hex_mode_in = hex_mode_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_HEX_MODE: csr_prdata = {31'd0, hex_mode_ff};
         REG_GUARD:    csr_prdata = {31'd0, guard_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_mode_ff <= 1'b0;
         guard_ff    <= 1'b1;
      end else begin
         hex_mode_ff <= hex_mode_in;
         guard_ff    <= guard_in;
      end
   end

   slee_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cfg      (cfg),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   slee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .stat      (q_stat),
      .head      (q_head)
   );

   slee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

`ifndef SYNTH
   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result register not cleared by reset");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_end) |-> rsp_data.out_run_last)
      else $error("end of literal without end of run");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("request pushed into full queue");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("request popped from empty queue");
`endif

endmodule

`default_nettype wire

[sv/slee_front.sv]
// ----------------------------------------------------------------------------
// slee_front
// Holds each byte until its successor arrives and encodes it into characters.
// ----------------------------------------------------------------------------
`default_nettype none

module slee_front import slee_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_push,
   input  wire req_type  req_data,
   output logic          req_full,
   input  wire cfg_type  cfg,
   input  wire qstat_type q_stat,
   output logic          q_push,
   output work_type      q_data
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   class_type  prior_ff, prior_in;

   logic      accept;
   enc_type   enc_a, enc_b;
   class_type class_a;

   assign req_full = q_stat.full;
   assign accept   = req_push && !q_stat.full;

   always_comb begin
      enc_a   = encode(held_byte_ff, req_data.in_byte, cfg, prior_ff);
      class_a = held_valid_ff ? enc_a.cls : prior_ff;
      // last byte of the buffer: successor counts as a non-digit
      enc_b   = encode(req_data.in_byte, 8'd0, cfg, class_a);

      q_data.a_chars = enc_a.chars;
      q_data.a_len   = held_valid_ff ? enc_a.len : 3'd0;
      q_data.b_chars = enc_b.chars;
      q_data.b_len   = req_data.in_last ? enc_b.len : 3'd0;
      q_data.last    = req_data.in_last;
      q_push         = accept && (held_valid_ff || req_data.in_last);

      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      prior_in      = prior_ff;
      if (accept) begin
         if (req_data.in_last) begin
            held_byte_in  = 8'd0;
            held_valid_in = 1'b0;
            prior_in      = CLASS_PRINTABLE;
         end else begin
            held_byte_in  = req_data.in_byte;
            held_valid_in = 1'b1;
            prior_in      = class_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         prior_ff      <= CLASS_PRINTABLE;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         prior_ff      <= prior_in;
      end
   end

endmodule

`default_nettype wire

[sv/slee_queue.sv]
// ----------------------------------------------------------------------------
// slee_queue
// Small FIFO of encoded requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module slee_queue import slee_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   input  wire logic     pop,
   output qstat_type     stat,
   output work_type      head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type       mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count_ff, count_in;
   logic           do_push, do_pop;

   assign stat.empty = (count_ff == (AW+1)'(0));
   assign stat.full  = (count_ff == (AW+1)'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/slee_back.sv]
// ----------------------------------------------------------------------------
// slee_back
// Walks the characters of the head request and feeds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slee_back import slee_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qstat_type q_stat,
   input  wire work_type  q_head,
   output logic           q_pop,
   output rsp_type        rsp_data,
   output logic           rsp_empty,
   input  wire logic      rsp_pop
);

   logic [2:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   logic       load;
   logic [3:0] total;
   logic [2:0] b_idx;
   logic       fin;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      load  = !q_stat.empty && (!out_valid_ff || rsp_pop);
      total = {1'b0, q_head.a_len} + {1'b0, q_head.b_len};
      b_idx = pos_ff - q_head.a_len;
      fin   = ({1'b0, pos_ff} + 4'd1) == total;
      q_pop = load && fin;

      out_data_in.out_char     = (pos_ff < q_head.a_len) ? q_head.a_chars[pos_ff[1:0]]
                                                         : q_head.b_chars[b_idx[1:0]];
      out_data_in.out_run_last = fin;
      out_data_in.out_end      = fin && q_head.last;

      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         pos_in       = fin ? 3'd0 : pos_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[test/tb_string_literal_escape_encoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_literal_escape_encoder_core
// Self-checking bench for the streaming C string literal encoder. A tracker
// class spells each accepted request byte the way the literal must read and
// queues the characters. Each popped character is compared field by field
// against that queue. The stimulus runs a directed opening and then random
// buffers under every register setting. Both sides idle at random, and once
// the result side holds off long enough to back up the request queue.
// ----------------------------------------------------------------------------

module tb_string_literal_escape_encoder_core;
   import slee_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [6:0] ASCII_BSLASH  = 7'd92;
   localparam logic [6:0] ASCII_ZERO    = 7'd48;
   localparam logic [6:0] ASCII_X       = 7'd120;
   localparam logic [6:0] ASCII_LOWER_A = 7'd97;
   localparam logic [7:0] PRINT_FIRST   = 8'd32;
   localparam logic [7:0] PRINT_LAST    = 8'd126;

   // Spells request bytes into literal characters and holds what is still owed
   class literal_tracker;
      logic       hex_mode;
      logic       guard;
      logic [7:0] held_byte;
      logic       held_valid;
      class_type  prior;
      logic [6:0] spelled[$];
      rsp_type    expected_chars[$];
      int         failures;
      int         checked;

      function new();
         hex_mode   = 1'b0;
         guard      = 1'b1;
         held_byte  = 8'd0;
         held_valid = 1'b0;
         prior      = CLASS_PRINTABLE;
         failures   = 0;
         checked    = 0;
      endfunction

      function bit is_decimal(logic [7:0] c);
         return c >= 8'd48 && c <= 8'd57;
      endfunction

      function bit is_hex_digit(logic [7:0] c);
         return is_decimal(c) || (c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70);
      endfunction

      function logic [6:0] escape_letter(logic [7:0] c);
         case (c)
            8'd7:    return 7'd97;
            8'd8:    return 7'd98;
            8'd9:    return 7'd116;
            8'd10:   return 7'd110;
            8'd11:   return 7'd118;
            8'd12:   return 7'd102;
            8'd13:   return 7'd114;
            8'd34:   return 7'd34;
            8'd39:   return 7'd39;
            8'd63:   return 7'd63;
            8'd92:   return 7'd92;
            default: return 7'd0;
         endcase
      endfunction

      function logic [6:0] nibble_char(logic [3:0] d);
         return (d < 4'd10) ? ASCII_ZERO + 7'(d) : ASCII_LOWER_A + 7'(d) - 7'd10;
      endfunction

      function void spell_numeric(logic [7:0] c);
         spelled.push_back(ASCII_BSLASH);
         if (hex_mode) begin
            spelled.push_back(ASCII_X);
            spelled.push_back(nibble_char(c[7:4]));
            spelled.push_back(nibble_char(c[3:0]));
         end else begin
            spelled.push_back(ASCII_ZERO + 7'(c[7:6]));
            spelled.push_back(ASCII_ZERO + 7'(c[5:3]));
            spelled.push_back(ASCII_ZERO + 7'(c[2:0]));
         end
         prior = CLASS_NUMERIC;
      endfunction

      function void spell_byte(logic [7:0] c, logic [7:0] nxt);
         logic [6:0] letter;
         letter = escape_letter(c);
         if (c == 8'd0) begin
            // short zero only when no digit follows
            if (!is_decimal(nxt)) begin
               spelled.push_back(ASCII_BSLASH);
               spelled.push_back(ASCII_ZERO);
               prior = hex_mode ? CLASS_SHORT : CLASS_NUMERIC;
            end else begin
               spell_numeric(c);
            end
         end else if (letter != 7'd0) begin
            spelled.push_back(ASCII_BSLASH);
            spelled.push_back(letter);
            prior = CLASS_SHORT;
         end else if (prior == CLASS_NUMERIC &&
                      (hex_mode ? is_hex_digit(c) : (guard && is_decimal(c)))) begin
            spell_numeric(c);
         end else if (c >= PRINT_FIRST && c <= PRINT_LAST) begin
            spelled.push_back(c[6:0]);
            prior = CLASS_PRINTABLE;
         end else begin
            spell_numeric(c);
         end
      endfunction

      function void note_byte(req_type r);
         rsp_type e;
         spelled = {};
         if (held_valid) spell_byte(held_byte, r.in_byte);
         if (r.in_last) begin
            spell_byte(r.in_byte, 8'd0);
            held_valid = 1'b0;
            held_byte  = 8'd0;
            prior      = CLASS_PRINTABLE;
         end else begin
            held_byte  = r.in_byte;
            held_valid = 1'b1;
         end
         foreach (spelled[k]) begin
            e.out_char     = spelled[k];
            e.out_run_last = (k == spelled.size() - 1);
            e.out_end      = (k == spelled.size() - 1) && r.in_last;
            expected_chars.push_back(e);
         end
      endfunction

      function void check_char(rsp_type got);
         rsp_type e;
         checked++;
         if (expected_chars.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected char %0d (run_last %0b end %0b) with nothing owed",
                        got.out_char, got.out_run_last, got.out_end);
            return;
         end
         e = expected_chars.pop_front();
         if (got.out_char != e.out_char || got.out_run_last != e.out_run_last ||
             got.out_end != e.out_end) begin
            failures++;
            if (failures <= 10)
               $display("char mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b (char/run_last/end)",
                        e.out_char, e.out_run_last, e.out_end,
                        got.out_char, got.out_run_last, got.out_end);
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   req_type     req_data    = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   literal_tracker tracker = new();
   int  cycle_count  = 0;
   int  full_stalls  = 0;
   int  sent_count   = 0;
   int  rush_left    = 0;
   int  send_calm    = 0;
   bit  hold_pop     = 1'b0;

   string_literal_escape_encoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_push && req_full) full_stalls <= full_stalls + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_string_literal_escape_encoder_core failed");
         $finish;
      end
   end

   // Random idle gap or none, with occasional stretches of back-to-back traffic
   function automatic int pick_gap(inout int calm);
      if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1: return 8'd0;
         2: return 8'($urandom_range(48, 57));
         3: return $urandom_range(0, 1) ? 8'($urandom_range(97, 102))
                                        : 8'($urandom_range(65, 70));
         4: begin
            if ($urandom_range(0, 1)) return 8'($urandom_range(7, 13));
            case ($urandom_range(0, 3))
               0: return 8'd34;
               1: return 8'd39;
               2: return 8'd63;
               default: return 8'd92;
            endcase
         end
         5: return 8'($urandom_range(0, 31));
         6: return 8'($urandom_range(127, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Keep push high across back-to-back requests; drop it only for a gap
   task automatic send_request(input req_type r);
      int gap;
      gap = pick_gap(send_calm);
      if (rush_left > 0) begin
         rush_left--;
         gap = 0;
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      tracker.note_byte(r);
      sent_count++;
   endtask

   task automatic send_random(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r.in_byte = pick_byte();
         r.in_last = ($urandom_range(0, 5) == 0);
         send_request(r);
      end
      req_push <= 1'b0;
   endtask

   // Wait out owed characters, then let a held byte settle inside the block
   task automatic wait_idle();
      while (tracker.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic hex, input logic grd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_HEX_MODE, 2'b00};
      csr_pwdata  <= 32'(hex);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_GUARD, 2'b00};
      csr_pwdata  <= 32'(grd);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.hex_mode = hex;
      tracker.guard    = grd;
   endtask

   task automatic run_phase(input logic hex, input logic grd, input int count,
                            input bit squeeze);
      wait_idle();
      write_config(hex, grd);
      if (squeeze) begin
         hold_pop  = 1'b1;
         rush_left = 30;
      end
      send_random(count);
   endtask

   // Result side: pop with random idling, plus one long hold-off on request
   initial begin : drain
      int calm;
      int gap;
      calm = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap(calm);
         if (hold_pop) begin
            hold_pop = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         tracker.check_char(rsp_data);
      end
   end

   initial begin : stimulus
      logic [7:0] opening_bytes [24];
      req_type    r;
      opening_bytes = '{8'h00, 8'h31, 8'h00, 8'h41, 8'h07, 8'h08, 8'h09, 8'h0a,
                        8'h0b, 8'h0c, 8'h0d, 8'h22, 8'h27, 8'h3f, 8'h5c, 8'h1f,
                        8'h20, 8'h7e, 8'h7f, 8'hff, 8'h80, 8'h39, 8'h00, 8'hff};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zeros before digits and letters, every short escape, range edges
      foreach (opening_bytes[i]) begin
         r.in_byte = opening_bytes[i];
         r.in_last = (i >= 22);
         send_request(r);
      end
      send_random(40);

      run_phase(1'b1, 1'b1, 45, 1'b0);
      run_phase(1'b0, 1'b0, 45, 1'b1);
      run_phase(1'b1, 1'b0, 45, 1'b0);
      run_phase(1'b0, 1'b1, 45, 1'b0);

      while (tracker.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d byte requests over octal/hex and guard on/off settings, %0d chars checked",
               sent_count, tracker.checked);
      $display("%0d cycles with the request side blocked on a full queue", full_stalls);
      if (tracker.failures == 0 && tracker.expected_chars.size() == 0) begin
         $display("tb_string_literal_escape_encoder_core passed");
      end else begin
         $display("%0d failures", tracker.failures);
         $display("tb_string_literal_escape_encoder_core failed");
      end
      $finish;
   end

endmodule
